/* src/lgpe_pkg.sv */
// ----------------------------------------------------------------------------
// lgpe_pkg
// Shared types, constants and helpers for the LCD ghosting pixel expander.
// ----------------------------------------------------------------------------
package lgpe_pkg;

  localparam int PIX_W      = 7;
  localparam int SHADE_W    = 2;
  localparam int LEVEL_W    = 5;
  localparam int LANES      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 5'b11111;
  localparam logic [7:0]         MAX_VISIBLE_W   = 8'd160;
  localparam logic [2:0]         RATE_BASE       = 3'd6;
  localparam logic [7:0]         MASK_BASE       = 8'hFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GHOST_LEVEL   = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic [2:0]       rate;
    logic [PIX_W-1:0] mask;
  } ghost_t;

  function automatic ghost_t ghost_params(input logic [2:0] level);
    ghost_t     g;
    logic [7:0] m;
    g.rate = (level < RATE_BASE) ? (RATE_BASE - level) : 3'd1;
    m      = MASK_BASE >> (4'(level) + 4'd1);
    g.mask = m[PIX_W-1:0];
    return g;
  endfunction

endpackage

/* src/lcd_ghosting_pixel_expander.sv */
// ----------------------------------------------------------------------------
// lcd_ghosting_pixel_expander
// Expands 2-bit-per-pixel video bytes into four 7-bit ghosted pixels.
//
// Input channel in_*: one video byte per transaction, in line order.
// Output channel out_*: four pixels plus line_end and frame_end flags, one
// result transaction for every input transaction, in order.
// Config channel cfg_*: index 0 pixel_offset, 1 visible_width (clamped to
// 160), 2 ghost_level; other indexes are ignored. cfg_ready is always high.
// A byte taken sits in the read stage, then moves on to the output register
// and leaves from there; with no output stall and no clearing pass, one byte
// is taken every cycle. The frame store is read as a byte is
// taken and written back when the byte moves to the output register;
// a byte reading the row being written in the same cycle gets forwarded data.
// After reset a clearing pass zeroes the frame store, one row of four pixels
// per cycle, across FRAME_LINES * ceil(FRAME_WIDTH/4) rows (6400 at defaults);
// in_stall is high while it runs. When out_stall holds the output register,
// one more byte is taken into the read stage; after that in_stall rises.
// ----------------------------------------------------------------------------
module lcd_ghosting_pixel_expander #(
  parameter int FRAME_WIDTH = 160,
  parameter int FRAME_LINES = 160
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_vram_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [6:0]                        out_pixel_a,
  output logic [6:0]                        out_pixel_b,
  output logic [6:0]                        out_pixel_c,
  output logic [6:0]                        out_pixel_d,
  output logic                              out_line_end,
  output logic                              out_frame_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lgpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgpe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WPL   = (FRAME_WIDTH + 3) / 4;
  localparam int DEPTH = WPL * FRAME_LINES;
  localparam int CW    = (WPL > 1) ? $clog2(WPL) : 1;
  localparam int LW    = (FRAME_LINES > 1) ? $clog2(FRAME_LINES) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W = lgpe_pkg::LANES * lgpe_pkg::PIX_W;

  localparam logic [8:0]    FW9       = 9'(FRAME_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0] WPL_A     = AW'(WPL);
  localparam logic [LW-1:0] LAST_LINE = LW'(FRAME_LINES - 1);

  // configuration
  logic [1:0] pix_off_r;
  logic [7:0] vis_w_r;
  logic [2:0] ghost_lvl_r;

  // clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // position counters
  logic [CW-1:0] col_r;
  logic [LW-1:0] line_r;
  logic [AW-1:0] line_base_r;

  // read stage
  logic                         s1_valid_r;
  logic [7:0]                   s1_byte_r;
  logic [AW-1:0]                s1_addr_r;
  logic [lgpe_pkg::LANES-1:0]   s1_lane_ok_r;
  logic                         s1_line_end_r;
  logic                         s1_frame_end_r;
  logic                         fwd_hit_r;
  logic [ROW_W-1:0]             fwd_row_r;

  // output register
  logic                         out_valid_r;
  lgpe_pkg::pixel_t             out_pix_r [lgpe_pkg::LANES];
  logic                         out_line_end_r;
  logic                         out_frame_end_r;

  logic                         in_acc;
  logic                         s2_load;
  logic                         s1_move;
  logic [8:0]                   eff_w;
  logic [8:0]                   bpl;
  logic [8:0]                   bpl_m1;
  logic                         line_end;
  logic                         frame_end;
  logic [7:0]                   byte_sh;
  logic [AW-1:0]                addr_s0;
  logic [lgpe_pkg::LANES-1:0]   lane_ok;
  logic [ROW_W-1:0]             ram_rdata;
  logic [ROW_W-1:0]             prev_row;
  logic [ROW_W-1:0]             new_row;
  lgpe_pkg::ghost_t             ghost;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ROW_W-1:0]             ram_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_off_r   <= '0;
      vis_w_r     <= lgpe_pkg::MAX_VISIBLE_W;
      ghost_lvl_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lgpe_pkg::CFG_PIXEL_OFFSET:  pix_off_r <= cfg_data[1:0];
        lgpe_pkg::CFG_VISIBLE_WIDTH: begin
          vis_w_r <= (cfg_data > lgpe_pkg::MAX_VISIBLE_W) ? lgpe_pkg::MAX_VISIBLE_W
                                                          : cfg_data;
        end
        lgpe_pkg::CFG_GHOST_LEVEL:   ghost_lvl_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign ghost = lgpe_pkg::ghost_params(ghost_lvl_r);

  // handshake
  assign s2_load  = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && s2_load;
  assign in_stall = clr_busy_r || (s1_valid_r && !s2_load);
  assign in_acc   = in_valid && !in_stall;

  // line geometry
  assign eff_w     = (9'(vis_w_r) > FW9) ? FW9 : 9'(vis_w_r);
  assign bpl       = (eff_w + 9'd3) >> 2;
  assign bpl_m1    = (bpl == '0) ? '0 : bpl - 9'd1;
  assign line_end  = 9'(col_r) >= bpl_m1;
  assign frame_end = line_end && (line_r == LAST_LINE);

  assign byte_sh = (col_r == '0) ? (in_vram_byte >> {pix_off_r, 1'b0}) : in_vram_byte;
  assign addr_s0 = line_base_r + AW'(col_r);

  always_comb begin
    for (int k = 0; k < lgpe_pkg::LANES; k++) begin
      lane_ok[k] = ((10'(col_r) << 2) + 10'(k)) < 10'(FRAME_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      line_r      <= '0;
      line_base_r <= '0;
    end else if (in_acc) begin
      if (line_end) begin
        col_r <= '0;
        if (frame_end) begin
          line_r      <= '0;
          line_base_r <= '0;
        end else begin
          line_r      <= line_r + LW'(1);
          line_base_r <= line_base_r + WPL_A;
        end
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        // row written back in the same cycle as this read
        fwd_hit_r  <= s1_move && (s1_addr_r == addr_s0);
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r      <= byte_sh;
      s1_addr_r      <= addr_s0;
      s1_lane_ok_r   <= lane_ok;
      s1_line_end_r  <= line_end;
      s1_frame_end_r <= frame_end;
      fwd_row_r      <= new_row;
    end
  end

  assign ram_we    = clr_busy_r || s1_move;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_busy_r ? '0 : new_row;

  lgpe_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (in_acc),
    .raddr   (addr_s0),
    .rdata_r (ram_rdata)
  );

  assign prev_row = fwd_hit_r ? fwd_row_r : ram_rdata;

  for (genvar k = 0; k < lgpe_pkg::LANES; k++) begin : g_lane
    lgpe_pkg::pixel_t lane_prev;
    lgpe_pkg::pixel_t lane_pix;

    // pixels beyond the stored width read as zero
    assign lane_prev = s1_lane_ok_r[k] ? prev_row[k*lgpe_pkg::PIX_W +: lgpe_pkg::PIX_W]
                                       : '0;

    lgpe_blend u_blend (
      .shade (s1_byte_r[2*k +: lgpe_pkg::SHADE_W]),
      .prev  (lane_prev),
      .ghost (ghost),
      .pix   (lane_pix)
    );

    assign new_row[k*lgpe_pkg::PIX_W +: lgpe_pkg::PIX_W] = lane_pix;

    always_ff @(posedge clk) begin
      if (s1_move) begin
        out_pix_r[k] <= lane_pix;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_line_end_r  <= s1_line_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_a   = out_pix_r[0];
  assign out_pixel_b   = out_pix_r[1];
  assign out_pixel_c   = out_pix_r[2];
  assign out_pixel_d   = out_pix_r[3];
  assign out_line_end  = out_line_end_r;
  assign out_frame_end = out_frame_end_r;

  // no transaction may be in flight while the store is being cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_valid_r && !out_valid_r))
    else $error("item in flight during store clearing");

  // line base tracks the line counter
  assert property (@(posedge clk) disable iff (!rst_n)
    line_base_r == AW'(32'(line_r) * WPL))
    else $error("line base out of step with line counter");

  // column stays inside the stored row range
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < WPL)
    else $error("column counter beyond row range");

  // frame end is only flagged together with line end
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && s1_frame_end_r |=> out_line_end_r && out_frame_end_r)
    else $error("frame end without line end");

endmodule

/* src/lgpe_ram.sv */
// ----------------------------------------------------------------------------
// lgpe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lgpe_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 6400
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* src/lgpe_blend.sv */
// ----------------------------------------------------------------------------
// lgpe_blend
// Blends one new 2-bit shade with the stored pixel of the previous frame.
// ----------------------------------------------------------------------------
module lgpe_blend (
  input  logic [lgpe_pkg::SHADE_W-1:0] shade,
  input  lgpe_pkg::pixel_t             prev,
  input  lgpe_pkg::ghost_t             ghost,
  output lgpe_pkg::pixel_t             pix
);

  logic [lgpe_pkg::LEVEL_W-1:0] p5;
  logic [lgpe_pkg::SHADE_W-1:0] old_shade;
  logic [10:0]                  rise;

  assign p5        = prev[lgpe_pkg::LEVEL_W-1:0];
  assign old_shade = prev[lgpe_pkg::PIX_W-1:lgpe_pkg::LEVEL_W];
  assign rise      = ({6'b0, p5} << ghost.rate) | {4'b0, ghost.mask};

  always_comb begin
    if (old_shade == shade) begin
      // same shade: level rises, saturating
      if (rise > 11'(lgpe_pkg::LEVEL_MAX)) begin
        pix = {shade, lgpe_pkg::LEVEL_MAX};
      end else begin
        pix = {shade, rise[lgpe_pkg::LEVEL_W-1:0]};
      end
    end else if (p5 == '0) begin
      pix = {shade, {lgpe_pkg::LEVEL_W{1'b0}}};
    end else begin
      // old shade lingers while its level decays
      pix = {old_shade, p5 >> ghost.rate};
    end
  end

endmodule
